>>> hdl/khc_pkg.sv
package khc_pkg;

  localparam int unsigned Rounds = 18;
  localparam int unsigned Shifts = 8;

  localparam logic [7:0] BaseLL = 8'h74;
  localparam logic [7:0] BaseLH = 8'h2E;
  localparam logic [7:0] BaseHL = 8'h3A;
  localparam logic [7:0] BaseHH = 8'h5C;

  localparam logic MODE_DECRYPT = 1'b0;
  localparam logic MODE_ENCRYPT = 1'b1;

  localparam logic REG_KEY = 1'b0;

  // one beat in flight: mode and the four byte registers
  // decrypt: b0..b3 = s0..s3, encrypt: b0..b3 = a,b,c,d
  typedef struct packed {
    logic       mode;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } khc_state_t;

  function automatic logic [7:0] pick_base(logic hi, logic lo);
    logic [7:0] r;
    if (!hi) r = lo ? BaseLH : BaseLL;
    else     r = lo ? BaseHH : BaseHL;
    return r;
  endfunction

  function automatic logic [7:0] key_byte(logic [63:0] key, logic [2:0] idx);
    return key[(7 - idx) * 8 +: 8];
  endfunction

endpackage

>>> hdl/khc_round.sv
module khc_round (
  input  khc_pkg::khc_state_t st_in,
  input  logic [7:0]          key_dec,
  input  logic [7:0]          key_enc,
  output khc_pkg::khc_state_t st_out
);
  import khc_pkg::*;

  // eight register shifts of one round, either direction
  always_comb begin
    logic [7:0] s0, s1, s2, s3, k, b, t, bf, nd, rdv;
    logic       fb;
    s0 = st_in.b0; s1 = st_in.b1; s2 = st_in.b2; s3 = st_in.b3;
    b = '0; t = '0; bf = '0; nd = '0; rdv = '0; fb = 1'b0;
    k = (st_in.mode == MODE_ENCRYPT) ? key_enc : key_dec;
    for (int i = 0; i < Shifts; i++) begin
      if (st_in.mode == MODE_DECRYPT) begin
        b = pick_base(s3[6], s3[1]);
        if (s2[3]) b = {b[3:0], b[7:4]};
        if (s1[0]) b = {b[5:0], 2'b00};
        if (s0[0]) b = {b[6:0], 1'b0};
        t  = s3 ^ s1;
        s3 = {s3[6:0], s2[7]};
        s2 = {s2[6:0], s1[7]};
        s1 = {s1[6:0], s0[7]};
        s0 = {s0[6:0], b[7] ^ k[7] ^ t[7]};
        k  = {k[6:0], 1'b0};
      end else begin
        // s0=a, s1=b, s2=c, s3=d (d runs as the round's working byte)
        rdv = s3;
        b = pick_base(s0[7], s0[2]);
        if (s2[4]) b = {b[3:0], b[7:4]};
        if (s1[1]) b = {b[5:0], 2'b00};
        bf  = rdv[1] ? {b[6:0], 1'b0} : b;
        nd  = {s1[0], rdv[7:1]};
        rdv = rdv ^ s2;
        s1  = {s2[0], s1[7:1]};
        s2  = {s0[0], s2[7:1]};
        fb  = rdv[0] ^ k[0] ^ bf[7];
        s0  = {fb, s0[7:1]};
        k   = {1'b0, k[7:1]};
        s3  = nd;
      end
    end
    st_out.mode = st_in.mode;
    st_out.b0 = s0; st_out.b1 = s1; st_out.b2 = s2; st_out.b3 = s3;
  end

endmodule

>>> hdl/keyfob_hop_cipher.sv
// An input beat passes the load register and then the 18 round stages before it leaves as the result beat.
// Throughput: one beat per cycle while the output is not stalled; 144 shifts split as 8 per stage over 18 stages.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous): clears all stage valid bits and the key to zero.
module keyfob_hop_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] hop_word,
  input  logic [27:0] serial_number,
  input  logic [15:0] count_value,
  input  logic [3:0]  button_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] decoded_count,
  output logic [31:0] encrypted_word
);
  import khc_pkg::*;

  logic [63:0] cipher_key;
  logic        vld [0:Rounds];
  khc_state_t  stg [0:Rounds];
  khc_state_t  rnd [0:Rounds-1];
  khc_state_t  load;
  logic        en;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_KEY) ? cipher_key : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 64'd0;
    end else if (psel && penable && pwrite && paddr[3] == REG_KEY) begin
      cipher_key <= pwdata;
    end
  end

  // global advance: move when the result register is free or taken
  assign en       = !vld[Rounds] || out_ready;
  assign in_ready = en;

  // load the byte registers
  always_comb begin
    load.mode = mode;
    if (mode == MODE_DECRYPT) begin
      load.b0 = hop_word[7:0];
      load.b1 = hop_word[15:8];
      load.b2 = hop_word[23:16];
      load.b3 = hop_word[31:24];
    end else begin
      load.b0 = {button_code, serial_number[11:8]};
      load.b1 = count_value[15:8];
      load.b2 = serial_number[7:0];
      load.b3 = count_value[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) stg[0] <= load;
  end

  // round stages
  for (genvar r = 0; r < Rounds; r++) begin : g_round
    localparam logic [2:0] KiDec = 3'((1 - r) & 7);
    localparam logic [2:0] KiEnc = 3'(r & 7);

    khc_round u_round (
      .st_in   (stg[r]),
      .key_dec (key_byte(cipher_key, KiDec)),
      .key_enc (key_byte(cipher_key, KiEnc)),
      .st_out  (rnd[r])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[r+1] <= 1'b0;
      end else if (en) begin
        vld[r+1] <= vld[r];
      end
    end

    always_ff @(posedge clk) begin
      if (en) stg[r+1] <= rnd[r];
    end
  end

  // result beat
  assign out_valid      = vld[Rounds];
  assign decoded_count  = (stg[Rounds].mode == MODE_DECRYPT) ?
                          {stg[Rounds].b1, stg[Rounds].b0} : 16'd0;
  assign encrypted_word = (stg[Rounds].mode == MODE_ENCRYPT) ?
                          {stg[Rounds].b0, stg[Rounds].b2, stg[Rounds].b1, stg[Rounds].b3}
                          : 32'd0;

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted beat missing from load stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld[Rounds] && $stable(stg[Rounds]))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> decoded_count == 16'd0 || encrypted_word == 32'd0)
    else $error("both result fields driven");

endmodule

>>> tb/keyfob_hop_cipher_test.sv
module keyfob_hop_cipher_test;
  import khc_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic        mode;
    logic [31:0] hop_word;
    logic [27:0] serial_number;
    logic [15:0] count_value;
    logic [3:0]  button_code;
  } frame_t;

  typedef struct packed {
    logic [15:0] decoded_count;
    logic [31:0] encrypted_word;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_DECRYPT;
  logic [31:0] hop_word = '0;
  logic [27:0] serial_number = '0;
  logic [15:0] count_value = '0;
  logic [3:0]  button_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] decoded_count;
  logic [31:0] encrypted_word;

  keyfob_hop_cipher dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // testbench copy of the key and the queues
  logic [63:0] model_key = '0;
  frame_t      pending_frames[$];
  answer_t     awaited_answers[$];
  int unsigned fail_count = 0;
  int unsigned hold_off = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [7:0] key_at(logic [63:0] key, int unsigned idx);
    return key[(7 - (idx % 8)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] base_of(logic hi, logic lo);
    if (!hi) return lo ? BaseLH : BaseLL;
    return lo ? BaseHH : BaseHL;
  endfunction

  function automatic logic [7:0] swap_nib(logic [7:0] v);
    return {v[3:0], v[7:4]};
  endfunction

  // backward cipher pass, low 16 bits of the register come out
  function automatic logic [15:0] recover_count(logic [63:0] key, logic [31:0] w);
    logic [7:0] s0, s1, s2, s3, k, b, t;
    int unsigned ki;
    s0 = w[7:0]; s1 = w[15:8]; s2 = w[23:16]; s3 = w[31:24];
    ki = 1;
    for (int r = 0; r < Rounds; r++) begin
      k = key_at(key, ki);
      for (int s = 0; s < Shifts; s++) begin
        b = base_of(s3[6], s3[1]);
        if (s2[3]) b = swap_nib(b);
        if (s1[0]) b = {b[5:0], 2'b00};
        if (s0[0]) b = {b[6:0], 1'b0};
        t = s3 ^ s1;
        s3 = {s3[6:0], s2[7]};
        s2 = {s2[6:0], s1[7]};
        s1 = {s1[6:0], s0[7]};
        s0 = {s0[6:0], 1'b0};
        s0[0] = b[7] ^ k[7] ^ t[7];
        k = {k[6:0], 1'b0};
      end
      ki = (ki + 7) % 8;
    end
    return {s1, s0};
  endfunction

  // forward cipher pass producing the hop word
  function automatic logic [31:0] hop_of(logic [63:0] key, logic [27:0] ser,
                                         logic [15:0] cnt, logic [3:0] btn);
    logic [7:0] a, b, c, d, k, rdv, base, bf, nd;
    logic fb;
    a = {btn, ser[11:8]}; b = cnt[15:8]; c = ser[7:0]; d = cnt[7:0];
    for (int r = 0; r < Rounds; r++) begin
      k = key_at(key, r);
      rdv = d;
      for (int s = 0; s < Shifts; s++) begin
        base = base_of(a[7], a[2]);
        if (c[4]) base = swap_nib(base);
        if (b[1]) base = {base[5:0], 2'b00};
        bf = rdv[1] ? {base[6:0], 1'b0} : base;
        nd = {b[0], rdv[7:1]};
        rdv = rdv ^ c;
        b = {c[0], b[7:1]};
        c = {a[0], c[7:1]};
        fb = (rdv[0] ^ k[0]) ^ bf[7];
        a = {fb, a[7:1]};
        k = k >> 1;
        rdv = nd;
      end
      d = rdv;
    end
    return {a, c, b, d};
  endfunction

  function automatic answer_t predict_answer(frame_t f);
    answer_t a;
    a = '0;
    if (f.mode == MODE_ENCRYPT)
      a.encrypted_word = hop_of(model_key, f.serial_number, f.count_value, f.button_code);
    else
      a.decoded_count = recover_count(model_key, f.hop_word);
    return a;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // driver: offers beats from the pending queue with random gaps
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_answers.push_back(predict_answer({mode, hop_word, serial_number,
                                                  count_value, button_code}));
        void'(pending_frames.pop_front());
        send_gap = gap_len();
      end
      if ((!in_valid || in_ready) ) begin
        if (send_gap == 0 && pending_frames.size() > 0) begin
          in_valid <= 1'b1;
          {mode, hop_word, serial_number, count_value, button_code} <= pending_frames[0];
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // monitor: random back-pressure, checks each result beat
  answer_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected beat", encrypted_word, 32'h0);
        end else begin
          want = awaited_answers.pop_front();
          if (decoded_count !== want.decoded_count)
            report_mismatch("decoded_count", 32'(decoded_count), 32'(want.decoded_count));
          if (encrypted_word !== want.encrypted_word)
            report_mismatch("encrypted_word", encrypted_word, want.encrypted_word);
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) < 70);
        if ($urandom_range(99) < 3) hold_off = $urandom_range(6, 1);
        else if ($urandom_range(999) < 3) hold_off = $urandom_range(60, 20);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_key(logic [63:0] value, logic [3:0] addr);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 4'(REG_KEY) * 8) model_key = value;
  endtask

  task automatic wait_idle();
    while (pending_frames.size() > 0 || in_valid || awaited_answers.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    f.mode = 1'($urandom_range(1));
    f.hop_word = $urandom;
    f.serial_number = 28'($urandom);
    f.count_value = 16'($urandom);
    f.button_code = 4'($urandom);
    return f;
  endfunction

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) pending_frames.push_back(random_frame());
    wait_idle();
  endtask

  initial begin
    logic [63:0] rk;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // zero key, extremes of every field in both modes
    pending_frames.push_back({MODE_DECRYPT, 32'h0, 28'h0, 16'h0, 4'h0});
    pending_frames.push_back({MODE_DECRYPT, 32'hFFFF_FFFF, 28'hFFF_FFFF, 16'hFFFF, 4'hF});
    pending_frames.push_back({MODE_ENCRYPT, 32'h0, 28'h0, 16'h0, 4'h0});
    pending_frames.push_back({MODE_ENCRYPT, 32'hFFFF_FFFF, 28'hFFF_FFFF, 16'hFFFF, 4'hF});
    // ignored serial bits and hop word in encrypt mode
    pending_frames.push_back({MODE_ENCRYPT, 32'h0, 28'hFFF_F000, 16'h1234, 4'h5});
    pending_frames.push_back({MODE_ENCRYPT, 32'hDEAD_BEEF, 28'h000_0FFF, 16'h0001, 4'h8});
    wait_idle();
    write_key(64'hFFFF_FFFF_FFFF_FFFF, 4'h0);
    pending_frames.push_back({MODE_DECRYPT, 32'h8000_0001, 28'h0, 16'h0, 4'h0});
    pending_frames.push_back({MODE_ENCRYPT, 32'h0, 28'h0AB_CDEF, 16'h8000, 4'hA});
    pending_frames.push_back({MODE_DECRYPT, 32'h0, 28'h0, 16'h0, 4'h0});
    pending_frames.push_back({MODE_ENCRYPT, 32'h0, 28'h0, 16'h0, 4'h0});
    wait_idle();
    // write to a bad index must leave the key alone
    write_key(64'h0123_4567_89AB_CDEF, 4'h8);
    pending_frames.push_back({MODE_DECRYPT, 32'h1234_5678, 28'h0, 16'h0, 4'h0});
    pending_frames.push_back({MODE_ENCRYPT, 32'h0, 28'h123, 16'h4567, 4'h3});
    wait_idle();
    write_key(64'h0123_4567_89AB_CDEF, 4'h0);
    // long hold-off on the receive side so the pipeline fills
    hold_off = 200;
    random_phase(60);
    for (int ph = 0; ph < 6; ph++) begin
      rk = {$urandom, $urandom};
      if (ph == 5) rk = 64'h0;
      write_key(rk, 4'h0);
      random_phase(240);
    end
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
